// ===== src/text_console_writer_defines.svh =====
// Assertion macros for the text console writer.
// TCW_ASSERT checks outside reset; TCW_ASSERT_RST also checks through reset.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TCW_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== src/tcw_pkg.sv =====
package tcw_pkg;

    localparam int CODE_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = 16;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;

    localparam int DEF_COLUMNS     = 80;
    localparam int DEF_ROWS        = 25;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CODE_RETURN    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h0A;

    localparam logic KIND_PRINT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef logic [2:0] t_op;
    localparam t_op OP_WRITE     = 3'd0;
    localparam t_op OP_NEWLINE   = 3'd1;
    localparam t_op OP_RETURN    = 3'd2;
    localparam t_op OP_BACKSPACE = 3'd3;
    localparam t_op OP_READ      = 3'd4;
    localparam t_op OP_READ_NULL = 3'd5;

    typedef struct packed {
        logic               kind;
        logic [CODE_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_pos;
        logic [CELL_W-1:0]   cell_value;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [CODE_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } t_cmd;

endpackage

// ===== src/tcw_front.sv =====
module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    input  logic     i_clearing,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam int CELLS = COLUMNS * ROWS;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_in_stall = i_clearing || (r_valid && i_q_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_cmd      = r_cmd;

    // Classify the item into one back-end operation.
    always_comb begin
        n_cmd.char_code  = i_in_item.char_code;
        n_cmd.cell_index = i_in_item.cell_index;
        if (i_in_item.kind == KIND_READ) begin
            n_cmd.op = (32'(i_in_item.cell_index) < 32'(CELLS)) ? OP_READ : OP_READ_NULL;
        end else begin
            case (i_in_item.char_code)
                CODE_NEWLINE:   n_cmd.op = OP_NEWLINE;
                CODE_RETURN:    n_cmd.op = OP_RETURN;
                CODE_BACKSPACE: n_cmd.op = OP_BACKSPACE;
                default:        n_cmd.op = OP_WRITE;
            endcase
        end
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== src/tcw_queue.sv =====
module tcw_queue import tcw_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/tcw_back.sv =====
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    input  logic              i_q_empty,
    input  t_cmd              i_head,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int LAST_START = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CODE_SPACE};

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_mem_q;

    logic [2:0]        r_state,    n_state;
    logic [ADDR_W-1:0] r_cnt,      n_cnt;
    logic [COL_W-1:0]  r_col,      n_col;
    logic [ROW_W-1:0]  r_row,      n_row;
    logic [ADDR_W-1:0] r_lin,      n_lin;
    logic [ADDR_W-1:0] r_rd_addr,  n_rd_addr;
    logic [ATTR_W-1:0] r_attr;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,      n_out;

    logic              out_free;
    logic              emit;
    logic [CELL_W-1:0] emit_val;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] row_start;
    logic              last_col;
    logic              last_row;
    logic [CELL_W-1:0] blank_cell;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign row_start   = r_lin - ADDR_W'(r_col);
    assign last_col    = (r_col == COL_W'(COLUMNS - 1));
    assign last_row    = (r_row == ROW_W'(ROWS - 1));
    assign blank_cell  = {r_attr, CODE_SPACE};
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_row       = r_row;
        n_lin       = r_lin;
        n_rd_addr   = r_rd_addr;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        emit        = 1'b0;
        emit_val    = '0;
        wr_en       = 1'b0;
        wr_addr     = r_lin;
        wr_data     = blank_cell;
        rd_addr     = r_rd_addr;

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = RESET_CELL;
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        OP_READ: begin
                            n_rd_addr = ADDR_W'(i_head.cell_index);
                            rd_addr   = n_rd_addr;
                            n_state   = S_READ;
                        end
                        OP_RETURN: begin
                            n_col = '0;
                            n_lin = row_start;
                            emit  = 1'b1;
                        end
                        OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                                n_lin = r_lin - 1'b1;
                            end else if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                                n_col = COL_W'(COLUMNS - 1);
                                n_lin = r_lin - 1'b1;
                            end
                            wr_en   = 1'b1;
                            wr_addr = n_lin;
                            emit    = 1'b1;
                        end
                        OP_NEWLINE: begin
                            n_col = '0;
                            if (last_row) begin
                                n_lin   = ADDR_W'(LAST_START);
                                n_cnt   = '0;
                                n_state = S_SHIFT;
                            end else begin
                                n_row = r_row + 1'b1;
                                n_lin = row_start + ADDR_W'(COLUMNS);
                                emit  = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            wr_en   = 1'b1;
                            wr_addr = r_lin;
                            wr_data = {r_attr, i_head.char_code};
                            if (last_col && last_row) begin
                                n_col   = '0;
                                n_lin   = ADDR_W'(LAST_START);
                                n_cnt   = '0;
                                n_state = S_SHIFT;
                            end else if (last_col) begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                                n_lin = r_lin + 1'b1;
                                emit  = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                                n_lin = r_lin + 1'b1;
                                emit  = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_val = r_mem_q;
                    n_state  = S_IDLE;
                end
            end

            S_SHIFT: begin
                if (r_cnt != ADDR_W'(LAST_START)) begin
                    rd_addr = r_cnt + ADDR_W'(COLUMNS);
                end
                if (r_cnt != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cnt - 1'b1;
                    wr_data = r_mem_q;
                end
                if (r_cnt == ADDR_W'(LAST_START)) begin
                    n_state = S_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_BLANK: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid      = 1'b1;
            n_out.cursor_pos = CURSOR_W'(n_lin);
            n_out.cell_value = emit_val;
        end
    end

    // Screen store: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_lin       <= '0;
            r_attr      <= RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_row       <= n_row;
            r_lin       <= n_lin;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
        r_rd_addr <= n_rd_addr;
        r_out     <= n_out;
    end

endmodule

// ===== src/text_console_writer.sv =====
// Text console writer: a character-cell screen of ROWS x COLUMNS cells (attribute in the
// high byte, character in the low byte) with a cursor. A print item handles newline,
// carriage return and backspace, and writes any other code at the cursor; a read item
// returns one cell, or zero for an index beyond the screen. Every result carries the
// linear cursor position, row * COLUMNS + col, truncated to 11 bits. After reset the block
// runs a clearing pass that writes a space in attribute 0x0A to every cell; input is held
// off with stall until it ends, while attribute writes are taken as usual. Items pass
// through a classify stage and a short command queue to the execution engine, which owns
// the screen memory and the cursor. In the engine the memory read for a read item is
// registered. A print that moves past the last row scrolls the screen: the engine copies
// every cell one row up through the single memory port pair, one cell a cycle, then blanks
// the bottom row. The front stage registers each item before it enters the queue; an empty
// queue presents a command at its head in the cycle after it is written. Write the
// attribute register only while no item is in flight.
`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int ROWS        = DEF_ROWS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // attribute register
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    // item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    localparam int CELLS = COLUMNS * ROWS;

    logic clearing;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    t_cmd front_cmd;
    t_cmd q_head;

    // Front: take a transfer in, classify it, hand it to the queue.
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    // Queue: decouple classification from execution so either side may hold.
    tcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: execute commands against the cursor and the screen store,
    // scroll when needed and drive the result register.
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // The reported cursor always lies on the screen.
    `TCW_ASSERT(a_cursor_on_screen, o_out_valid |-> (32'(o_out_item.cursor_pos) < 32'(CELLS)), "cursor position beyond the screen")
    // No item enters while the screen is being cleared.
    `TCW_ASSERT(a_hold_while_clearing, clearing |-> o_in_stall, "item taken during the clearing pass")
    // Reset drops any result and starts the clearing pass.
    `TCW_ASSERT_RST(a_reset_starts_clear, !i_rst_n |=> (!o_out_valid && clearing), "reset did not restart clearing")
    // A result never appears while the clearing pass runs.
    `TCW_ASSERT(a_no_result_while_clearing, clearing |-> !o_out_valid, "result during the clearing pass")

endmodule
